[rtl/core/uart_rfm_pkg.sv]
`default_nettype none

package uart_rfm_pkg;

    // operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_POLL  = 2'd2;

    // register selects
    localparam logic [1:0] SEL_DATA    = 2'd0;
    localparam logic [1:0] SEL_STATUS  = 2'd1;
    localparam logic [1:0] SEL_CONTROL = 2'd2;

    // status bit positions
    localparam int ST_RXC  = 7;
    localparam int ST_TXC  = 6;
    localparam int ST_UDRE = 5;

    // status after reset: data empty set
    localparam logic [7:0] STATUS_RESET = 8'h20;

    // control bit positions
    localparam int CT_RXCIE = 7;
    localparam int CT_TXCIE = 6;
    localparam int CT_UDRIE = 5;
    localparam int CT_RXEN  = 4;
    localparam int CT_TXEN  = 3;

    localparam int LOW_W = 5;

    typedef struct packed {
        logic [1:0] operation;
        logic [1:0] reg_select;
        logic [7:0] write_data;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       tx_ready;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       rx_taken;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq_rx_complete;
        logic       irq_tx_complete;
        logic       irq_data_empty;
    } t_rsp;

endpackage

`default_nettype wire

[rtl/core/uart_register_file_model_unit.sv]
`default_nettype none

// Serial-port register block: data, status and control registers.
// Input channel (i_in_valid / o_in_stall / i_in_req) carries one request per
// cycle while o_in_stall is low: a bus read, a bus write, or a host poll with
// an optional received byte and a transmitter-ready flag.
// Output channel (o_out_valid / i_out_stall / o_out_rsp) returns exactly one
// response per request, in order: read data, rx/tx handoff and irq pulses.
// The request is registered first; the register update and the response
// register write then happen together in one pass.
// Throughput: one request per clock; the request register and the response
// register each hold one entry, so the block keeps taking requests while
// the response side is free.
// Reset (i_rst_n low, synchronous): both stages empty, all registers zero
// except status data-empty, which is set.
// When the receiver stalls, the response register holds, the request stage
// fills and then o_in_stall rises until the response is taken.
module uart_register_file_model_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire uart_rfm_pkg::t_req  i_in_req,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output uart_rfm_pkg::t_rsp       o_out_rsp
);
    import uart_rfm_pkg::*;

    logic r_req_valid;
    t_req r_req;
    logic out_ready;
    logic advance;
    t_rsp core_rsp;

    assign advance    = r_req_valid && out_ready;
    assign o_in_stall = r_req_valid && !out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_req_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_req <= i_in_req;
        end
    end

    uart_rfm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_req   (r_req),
        .o_rsp   (core_rsp)
    );

    uart_rfm_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_req_valid),
        .i_rsp   (core_rsp),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_rsp   (o_out_rsp)
    );

endmodule

`default_nettype wire

[rtl/core/uart_rfm_core.sv]
`default_nettype none

module uart_rfm_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire uart_rfm_pkg::t_req  i_req,
    output uart_rfm_pkg::t_rsp       o_rsp
);
    import uart_rfm_pkg::*;

    logic [7:0]       r_rx_data, n_rx_data;
    logic [7:0]       r_tx_data, n_tx_data;
    logic [7:0]       r_status,  n_status;
    logic [7:0]       r_control, n_control;
    logic [7:0]       r_data_cell, n_data_cell;
    logic [LOW_W-1:0] r_low_cell, n_low_cell;

    logic rx_go;
    logic tx_go;

    always_comb begin
        n_rx_data   = r_rx_data;
        n_tx_data   = r_tx_data;
        n_status    = r_status;
        n_control   = r_control;
        n_data_cell = r_data_cell;
        n_low_cell  = r_low_cell;
        o_rsp       = '0;
        rx_go       = 1'b0;
        tx_go       = 1'b0;

        case (i_req.operation)
            OP_READ: begin
                case (i_req.reg_select)
                    SEL_DATA: begin
                        if (r_control[CT_RXEN] && r_status[ST_RXC]) begin
                            o_rsp.read_data  = r_rx_data;
                            n_status[ST_RXC] = 1'b0;
                        end else begin
                            o_rsp.read_data = r_data_cell;
                        end
                    end
                    SEL_STATUS:  o_rsp.read_data = {3'b000, r_low_cell} | r_status;
                    SEL_CONTROL: o_rsp.read_data = r_control;
                    default:     o_rsp.read_data = '0;
                endcase
            end
            OP_WRITE: begin
                case (i_req.reg_select)
                    SEL_DATA: begin
                        if (r_control[CT_TXEN] && r_status[ST_UDRE]) begin
                            n_tx_data         = i_req.write_data;
                            n_status[ST_TXC]  = 1'b0;
                            n_status[ST_UDRE] = 1'b0;
                        end
                        n_data_cell = i_req.write_data;
                    end
                    SEL_STATUS:  n_low_cell = i_req.write_data[LOW_W-1:0];
                    SEL_CONTROL: n_control  = i_req.write_data;
                    default: ;
                endcase
            end
            OP_POLL: begin
                // receive and transmit sides look at separate flags
                rx_go = r_control[CT_RXEN] && !r_status[ST_RXC] && i_req.rx_valid;
                tx_go = r_control[CT_TXEN] && !r_status[ST_UDRE] && i_req.tx_ready;
                if (rx_go) begin
                    n_rx_data             = i_req.rx_byte;
                    n_status[ST_RXC]      = 1'b1;
                    o_rsp.rx_taken        = 1'b1;
                    o_rsp.irq_rx_complete = r_control[CT_RXCIE];
                end
                if (tx_go) begin
                    n_status[ST_TXC]      = 1'b1;
                    n_status[ST_UDRE]     = 1'b1;
                    o_rsp.tx_valid        = 1'b1;
                    o_rsp.tx_byte         = r_tx_data;
                    o_rsp.irq_tx_complete = r_control[CT_TXCIE];
                    o_rsp.irq_data_empty  = r_control[CT_UDRIE];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_data   <= '0;
            r_tx_data   <= '0;
            r_status    <= STATUS_RESET;
            r_control   <= '0;
            r_data_cell <= '0;
            r_low_cell  <= '0;
        end else if (i_fire) begin
            r_rx_data   <= n_rx_data;
            r_tx_data   <= n_tx_data;
            r_status    <= n_status;
            r_control   <= n_control;
            r_data_cell <= n_data_cell;
            r_low_cell  <= n_low_cell;
        end
    end

endmodule

`default_nettype wire

[rtl/core/uart_rfm_out_reg.sv]
`default_nettype none

module uart_rfm_out_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire uart_rfm_pkg::t_rsp  i_rsp,
    output logic                     o_ready,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output uart_rfm_pkg::t_rsp       o_rsp
);
    import uart_rfm_pkg::*;

    logic r_valid;
    t_rsp r_rsp;

    // slot frees up in the same cycle the receiver takes the held response
    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rsp <= i_rsp;
        end
    end

endmodule

`default_nettype wire
